>>> hdl/smd_pkg.sv
// Shared constants and payload types for the scaled multiply-divide pipeline.
`default_nettype none

package smd_pkg;

    localparam int XW         = 32;
    localparam int NW         = 16;
    localparam int DW         = 16;
    localparam int PW         = XW + NW;
    localparam int QW         = 31;
    localparam int RW         = 17;
    localparam int QMAG_W     = QW - 1;
    localparam int STEP_BITS  = 4;
    localparam int DIV_STAGES = PW / STEP_BITS;
    localparam int FRONT_ST   = 2;
    localparam int NST        = FRONT_ST + DIV_STAGES + 1;

    typedef struct packed {
        logic          neg;
        logic [XW-1:0] mag;
        logic [NW-1:0] n;
        logic [DW-1:0] d;
    } mag_t;

    typedef struct packed {
        logic          neg;
        logic          dz;
        logic [DW-1:0] d;
        logic [DW-1:0] rem;
        logic [PW-1:0] acc;
    } div_t;

endpackage

`default_nettype wire

>>> hdl/smd_front.sv
// Front stages: take the magnitude of the value, then form the full product.
`default_nettype none

module smd_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [1:0]                 en,
    input  wire logic                       vld_in,
    input  wire logic [smd_pkg::XW-1:0]     value_in,
    input  wire logic [smd_pkg::NW-1:0]     multiplier,
    input  wire logic [smd_pkg::DW-1:0]     divisor,
    output logic [1:0]                      vld,
    output smd_pkg::div_t                   data_out
);

    smd_pkg::mag_t mag_reg;
    smd_pkg::mag_t mag_next;
    smd_pkg::div_t prod_reg;
    smd_pkg::div_t prod_next;
    logic [1:0]    vld_reg;

    always_comb
    begin
        mag_next.neg = value_in[smd_pkg::XW-1];
        mag_next.mag = value_in[smd_pkg::XW-1] ? (~value_in + 1'b1) : value_in;
        mag_next.n   = multiplier;
        mag_next.d   = divisor;
    end

    always_comb
    begin
        prod_next.neg = mag_reg.neg;
        prod_next.dz  = (mag_reg.d == '0);
        prod_next.d   = mag_reg.d;
        prod_next.rem = '0;
        prod_next.acc = {{smd_pkg::NW{1'b0}}, mag_reg.mag} *
                        {{smd_pkg::XW{1'b0}}, mag_reg.n};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= vld_in;
            end
            if (en[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && vld_in)
        begin
            mag_reg <= mag_next;
        end
        if (en[1] && vld_reg[0])
        begin
            prod_reg <= prod_next;
        end
    end

    assign vld      = vld_reg;
    assign data_out = prod_reg;

endmodule

`default_nettype wire

>>> hdl/smd_div_stage.sv
// One divider stage: a few restoring long-division steps, registered.
`default_nettype none

module smd_div_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vld_in,
    input  wire smd_pkg::div_t data_in,
    output logic               vld_out,
    output smd_pkg::div_t      data_out
);

    smd_pkg::div_t          data_reg;
    smd_pkg::div_t          data_next;
    logic                   vld_reg;

    always_comb
    begin
        logic [smd_pkg::DW:0]   part;
        logic                   take;
        data_next = data_in;
        for (int i = 0; i < smd_pkg::STEP_BITS; i++)
        begin
            part = {data_next.rem, data_next.acc[smd_pkg::PW-1]};
            take = (part >= {1'b0, data_next.d});
            if (take)
            begin
                part = part - {1'b0, data_next.d};
            end
            data_next.rem = part[smd_pkg::DW-1:0];
            data_next.acc = {data_next.acc[smd_pkg::PW-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_in)
        begin
            data_reg <= data_next;
        end
    end

    assign vld_out  = vld_reg;
    assign data_out = data_reg;

endmodule

`default_nettype wire

>>> hdl/smd_out.sv
// Output stage: overflow and zero-divisor handling, sign, result register.
`default_nettype none

module smd_out (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       vld_in,
    input  wire smd_pkg::div_t              data_in,
    output logic                            vld_out,
    output logic signed [smd_pkg::QW-1:0]   quotient,
    output logic signed [smd_pkg::RW-1:0]   remainder_out,
    output logic                            overflow
);

    logic                       vld_reg;
    logic [smd_pkg::QW-1:0]     quot_reg;
    logic [smd_pkg::QW-1:0]     quot_next;
    logic [smd_pkg::RW-1:0]     rem_reg;
    logic [smd_pkg::RW-1:0]     rem_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic [smd_pkg::QW-1:0]     qmag;
    logic [smd_pkg::RW-1:0]     rmag;

    always_comb
    begin
        ovf_next = data_in.dz || (|data_in.acc[smd_pkg::PW-1:smd_pkg::QMAG_W]);
        if (ovf_next)
        begin
            qmag = {{(smd_pkg::QW-1){1'b0}}, 1'b1};
        end
        else
        begin
            qmag = {1'b0, data_in.acc[smd_pkg::QMAG_W-1:0]};
        end
        rmag      = data_in.dz ? '0 : {1'b0, data_in.rem};
        quot_next = data_in.neg ? (~qmag + 1'b1) : qmag;
        rem_next  = data_in.neg ? (~rmag + 1'b1) : rmag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_in)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign vld_out       = vld_reg;
    assign quotient      = quot_reg;
    assign remainder_out = rem_reg;
    assign overflow      = ovf_reg;

endmodule

`default_nettype wire

>>> hdl/scaled_multiply_divide.sv
// Top level of the pipelined scaled multiply-divide (x*n/d, split remainder).
//
//   channel | handshake             | fields
//   --------+-----------------------+-----------------------------------------
//   arg     | arg_valid, arg_stall  | value_in, multiplier, divisor
//   res     | res_valid, res_stall  | quotient, remainder_out, overflow
//
// One item a cycle while res_stall is low. Stages: magnitude, 48-bit product,
// twelve four-step restoring divider stages, then the signed result register.
// Reset clears the valid bit of every stage; the data registers are not reset.
// Each stage advances when the next one is empty or advancing, so bubbles close
// up and new items are taken while a finished result waits under res_stall.
`default_nettype none

module scaled_multiply_divide (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       arg_valid,
    output logic                            arg_stall,
    input  wire logic signed [31:0]         value_in,
    input  wire logic [15:0]                multiplier,
    input  wire logic [15:0]                divisor,
    output logic                            res_valid,
    input  wire logic                       res_stall,
    output logic signed [30:0]              quotient,
    output logic signed [16:0]              remainder_out,
    output logic                            overflow
);

    localparam int NST = smd_pkg::NST;
    localparam int NDV = smd_pkg::DIV_STAGES;
    localparam int FST = smd_pkg::FRONT_ST;

    logic [NST-1:0]     en;
    logic [NST-1:0]     vld;
    smd_pkg::div_t      div_bus [NDV+1];

    assign en[NST-1] = !vld[NST-1] || !res_stall;

    genvar g;
    generate
        for (g = 0; g < NST - 1; g++)
        begin : g_en
            assign en[g] = !vld[g] || en[g+1];
        end
    endgenerate

    assign arg_stall = !en[0];

    smd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en[FST-1:0]),
        .vld_in     (arg_valid),
        .value_in   (value_in),
        .multiplier (multiplier),
        .divisor    (divisor),
        .vld        (vld[FST-1:0]),
        .data_out   (div_bus[0])
    );

    generate
        for (g = 0; g < NDV; g++)
        begin : g_div
            smd_div_stage u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en[FST+g]),
                .vld_in   (vld[FST+g-1]),
                .data_in  (div_bus[g]),
                .vld_out  (vld[FST+g]),
                .data_out (div_bus[g+1])
            );
        end
    endgenerate

    smd_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en[NST-1]),
        .vld_in        (vld[NST-2]),
        .data_in       (div_bus[NDV]),
        .vld_out       (vld[NST-1]),
        .quotient      (quotient),
        .remainder_out (remainder_out),
        .overflow      (overflow)
    );

    assign res_valid = vld[NST-1];

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the scaled multiply-divide pipeline.
`default_nettype none

module tb;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES   = 40;
    localparam logic [63:0] HALF_ONE       = 64'd1 << 15;
    localparam logic [63:0] HALF_MASK      = HALF_ONE - 64'd1;

    typedef struct packed {
        logic signed [smd_pkg::QW-1:0] quot;
        logic signed [smd_pkg::RW-1:0] rem;
        logic                          ovf;
    } smd_result_t;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          arg_valid     = 1'b0;
    logic                          arg_stall;
    logic signed [smd_pkg::XW-1:0] value_in      = '0;
    logic [smd_pkg::NW-1:0]        multiplier    = '0;
    logic [smd_pkg::DW-1:0]        divisor       = '0;
    logic                          res_valid;
    logic                          res_stall     = 1'b0;
    logic signed [smd_pkg::QW-1:0] quotient;
    logic signed [smd_pkg::RW-1:0] remainder_out;
    logic                          overflow;

    smd_result_t pending_results[$];
    int          error_count  = 0;
    int          quiet_cycles = 0;
    bit          sender_gaps  = 1'b1;
    bit          receiver_gaps = 1'b1;

    scaled_multiply_divide u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .arg_valid     (arg_valid),
        .arg_stall     (arg_stall),
        .value_in      (value_in),
        .multiplier    (multiplier),
        .divisor       (divisor),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .quotient      (quotient),
        .remainder_out (remainder_out),
        .overflow      (overflow)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic smd_result_t scale_divide(input logic [smd_pkg::XW-1:0] x,
                                                 input logic [smd_pkg::NW-1:0] n,
                                                 input logic [smd_pkg::DW-1:0] d);
        logic          sign;
        logic [31:0]   mag;
        logic [63:0]   mag_lo, mag_hi, nn, dd;
        logic [63:0]   lo_prod, hi_sum, mixed, hi_quot, qmag, rmag, signed_q, signed_r;
        logic          ovf;
        smd_result_t   res;
        sign = x[smd_pkg::XW-1];
        mag = sign ? (~x + 32'd1) : x;
        mag_lo = {49'd0, mag[14:0]};
        mag_hi = {47'd0, mag[31:15]};
        nn = {48'd0, n};
        dd = {48'd0, d};
        if (d == '0)
        begin
            qmag = 64'd1;
            rmag = 64'd0;
            ovf = 1'b1;
        end
        else
        begin
            lo_prod = mag_lo * nn;
            hi_sum = mag_hi * nn + (lo_prod >> 15);
            mixed = (hi_sum % dd) * HALF_ONE + (lo_prod & HALF_MASK);
            hi_quot = hi_sum / dd;
            rmag = mixed % dd;
            if (hi_quot >= HALF_ONE)
            begin
                qmag = 64'd1;
                ovf = 1'b1;
            end
            else
            begin
                qmag = hi_quot * HALF_ONE + mixed / dd;
                ovf = 1'b0;
            end
        end
        signed_q = sign ? (64'd0 - qmag) : qmag;
        signed_r = sign ? (64'd0 - rmag) : rmag;
        res.quot = signed_q[smd_pkg::QW-1:0];
        res.rem = signed_r[smd_pkg::RW-1:0];
        res.ovf = ovf;
        return res;
    endfunction

    task automatic send_item(input logic [smd_pkg::XW-1:0] x,
                             input logic [smd_pkg::NW-1:0] n,
                             input logic [smd_pkg::DW-1:0] d);
        if (sender_gaps && $urandom_range(99) < 6)
        begin
            arg_valid <= 1'b0;
            @(negedge clk);
        end
        arg_valid <= 1'b1;
        value_in <= x;
        multiplier <= n;
        divisor <= d;
        @(posedge clk);
        while (arg_stall)
        begin
            @(posedge clk);
        end
        pending_results.push_back(scale_divide(x, n, d));
        @(negedge clk);
    endtask

    function automatic logic [smd_pkg::XW-1:0] rand_value();
        logic [smd_pkg::XW-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(0, 200000);
            2: v = 32'h7FFF_FFFF - $urandom_range(0, 40000);
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(1))
        begin
            v = ~v + 32'd1;
        end
        return v;
    endfunction

    function automatic logic [15:0] rand_factor();
        case ($urandom_range(19))
            0: return 16'd0;
            1, 2, 3: return 16'($urandom_range(1, 16));
            4, 5: return 16'hFFFF - 16'($urandom_range(0, 16));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_field_extremes();
        send_item(32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_item(32'h8000_0001, 16'hFFFF, 16'hFFFF);
        send_item(32'h0000_0001, 16'd1, 16'd1);
        send_item(32'hFFFF_FFFF, 16'd1, 16'd1);
        send_item(32'h7FFF_FFFF, 16'd1, 16'hFFFF);
        send_item(32'h8000_0001, 16'd1, 16'hFFFF);
        send_item(32'h0000_7FFF, 16'hFFFF, 16'd3);
        send_item(32'h0000_8000, 16'h8000, 16'h7FFF);
        send_item(32'h5555_5555, 16'hAAAA, 16'h5555);
        send_item(32'hAAAA_AAAA, 16'h5555, 16'hAAAA);
    endtask

    task automatic test_special_cases();
        send_item(32'h8000_0000, 16'd1, 16'd1);
        send_item(32'h8000_0000, 16'hFFFF, 16'hFFFF);
        send_item(32'h8000_0000, 16'd1, 16'd2);
        send_item(32'h1234_5678, 16'd0, 16'd77);
        send_item(32'hEDCB_A988, 16'd0, 16'd77);
        send_item(32'h1234_5678, 16'd99, 16'd0);
        send_item(32'hEDCB_A988, 16'd99, 16'd0);
        send_item(32'h0000_0000, 16'd0, 16'd0);
        send_item(32'h0000_0000, 16'hFFFF, 16'd1);
        send_item(32'h4000_0000, 16'd1, 16'd1);
        send_item(32'hC000_0000, 16'd1, 16'd1);
        send_item(32'h3FFF_FFFF, 16'd1, 16'd1);
        send_item(32'h7FFF_FFFF, 16'hFFFF, 16'd1);
    endtask

    task automatic test_random_mixed(input int count);
        repeat (count)
        begin
            send_item(rand_value(), rand_factor(), rand_factor());
        end
    endtask

    task automatic test_random_no_gaps(input int count);
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        test_random_mixed(count);
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task automatic test_overflow_boundary(input int count);
        logic [smd_pkg::XW-1:0] x;
        logic [smd_pkg::NW-1:0] n;
        logic [smd_pkg::DW-1:0] d;
        repeat (count)
        begin
            d = 16'($urandom_range(1, 65535));
            n = 16'($urandom_range(1, 65535));
            x = 32'((64'd1 << 30) * d / n) + 32'($urandom_range(0, 4)) - 32'd2;
            x[31] = 1'b0;
            if ($urandom_range(1))
            begin
                x = ~x + 32'd1;
            end
            send_item(x, n, d);
        end
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            res_stall <= receiver_gaps && ($urandom_range(99) < 6);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result q=%0d r=%0d ovf=%0b", $time,
                         quotient, remainder_out, overflow);
                error_count++;
            end
            else
            begin
                smd_result_t want;
                want = pending_results.pop_front();
                if (quotient !== want.quot)
                begin
                    $display("%0t: quotient expected %0d actual %0d", $time,
                             want.quot, quotient);
                    error_count++;
                end
                if (remainder_out !== want.rem)
                begin
                    $display("%0t: remainder_out expected %0d actual %0d", $time,
                             want.rem, remainder_out);
                    error_count++;
                end
                if (overflow !== want.ovf)
                begin
                    $display("%0t: overflow expected %0b actual %0b", $time,
                             want.ovf, overflow);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((arg_valid && !arg_stall) || (res_valid && !res_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_field_extremes();
        test_special_cases();
        test_random_mixed(700);
        test_random_no_gaps(400);
        test_overflow_boundary(150);
        test_random_mixed(250);
        arg_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hdl/smd_pkg.sv
hdl/smd_front.sv
hdl/smd_div_stage.sv
hdl/smd_out.sv
hdl/scaled_multiply_divide.sv
verif/tb.sv
